@@ design/cfe_pkg.sv @@
// ----------------------------------------------------------------------------
// cfe_pkg: shared types and helpers for the CRC framed packet encoder
// Holds the transaction payload types, register indexes, operation codes and
// the CRC-16/CCITT byte fold used by the frame controller and serializer.
// ----------------------------------------------------------------------------
package cfe_pkg;

  localparam int unsigned IdxW = 4;  // byte position within one job, 0..13

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // operation codes
  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_START_FIRST  = 2'd0;
  localparam logic [1:0] REG_START_SECOND = 2'd1;
  localparam logic [1:0] REG_VERSION      = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [7:0]  frame_type;
    logic [15:0] sequence_req;
    logic [7:0]  command;
    logic [7:0]  status_code;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_first;
    logic [7:0] start_second;
    logic [7:0] version;
  } cfg_t;

  // one unit of output work: a full header burst or a single payload byte
  typedef struct packed {
    logic        is_hdr;
    logic        with_crc;   // append the two payload CRC bytes
    logic [7:0]  frame_type;
    logic [15:0] sequence_req;
    logic [7:0]  command;
    logic [7:0]  status_code;
    logic [15:0] payload_length;
    logic [7:0]  data;
    logic [15:0] crc;        // payload CRC to append when with_crc is set
  } job_t;

  function automatic logic [15:0] crc_fold(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ design/cfe_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// cfe_cfg_regs: configuration register file
// Three byte-wide registers for the start markers and version byte.
// Writes to an index beyond the list are dropped.
// ----------------------------------------------------------------------------
module cfe_cfg_regs
  import cfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_START_FIRST:  cfg_d.start_first  = cfg_data_i;
        REG_START_SECOND: cfg_d.start_second = cfg_data_i;
        REG_VERSION:      cfg_d.version      = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/cfe_frame_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfe_frame_ctrl: frame state and job builder
// Tracks the payload bytes still owed and the running payload CRC, and turns
// each accepted transaction into a job for the serializer.
// ----------------------------------------------------------------------------
module cfe_frame_ctrl
  import cfe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     job_valid_o,
  output job_t     job_o
);

  logic [15:0] remaining_q, remaining_d;
  logic [15:0] crc_q, crc_d;
  logic        in_payload_q, in_payload_d;
  logic [15:0] crc_next;

  assign crc_next = crc_fold(crc_q, item_i.payload_byte);

  always_comb begin
    remaining_d  = remaining_q;
    crc_d        = crc_q;
    in_payload_d = in_payload_q;
    job_valid_o  = 1'b0;

    job_o.is_hdr         = (item_i.operation == OP_HEADER);
    job_o.with_crc       = 1'b0;
    job_o.frame_type     = item_i.frame_type;
    job_o.sequence_req   = item_i.sequence_req;
    job_o.command        = item_i.command;
    job_o.status_code    = item_i.status_code;
    job_o.payload_length = item_i.payload_length;
    job_o.data           = item_i.payload_byte;
    job_o.crc            = crc_next;

    if (item_i.operation == OP_HEADER) begin
      job_valid_o    = 1'b1;
      job_o.with_crc = (item_i.payload_length == 16'd0);
      job_o.crc      = CrcInit;
      if (accept_i) begin
        crc_d        = CrcInit;
        remaining_d  = item_i.payload_length;
        in_payload_d = (item_i.payload_length != 16'd0);
      end
    end else if (in_payload_q && (remaining_q != 16'd0)) begin
      job_valid_o    = 1'b1;
      job_o.with_crc = (remaining_q == 16'd1);
      if (accept_i) begin
        crc_d       = crc_next;
        remaining_d = remaining_q - 16'd1;
        if (remaining_q == 16'd1) begin
          in_payload_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q  <= '0;
      crc_q        <= CrcInit;
      in_payload_q <= 1'b0;
    end else begin
      remaining_q  <= remaining_d;
      crc_q        <= crc_d;
      in_payload_q <= in_payload_d;
    end
  end

endmodule

@@ design/cfe_serializer.sv @@
// ----------------------------------------------------------------------------
// cfe_serializer: job register, byte sequencer and output register
// Walks a job one byte per cycle unless stalled, folds the header CRC as
// header bytes go out and holds each result in a stall-aware output register.
// ----------------------------------------------------------------------------
module cfe_serializer
  import cfe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      job_load_i,
  input  job_t      job_i,
  output logic      job_ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam logic [IdxW-1:0] PosStartFirst  = 4'd0;
  localparam logic [IdxW-1:0] PosStartSecond = 4'd1;
  localparam logic [IdxW-1:0] PosVersion     = 4'd2;
  localparam logic [IdxW-1:0] PosType        = 4'd3;
  localparam logic [IdxW-1:0] PosSeqLo       = 4'd4;
  localparam logic [IdxW-1:0] PosSeqHi       = 4'd5;
  localparam logic [IdxW-1:0] PosCommand     = 4'd6;
  localparam logic [IdxW-1:0] PosStatus      = 4'd7;
  localparam logic [IdxW-1:0] PosLenLo       = 4'd8;
  localparam logic [IdxW-1:0] PosLenHi       = 4'd9;
  localparam logic [IdxW-1:0] PosHcrcLo      = 4'd10;
  localparam logic [IdxW-1:0] PosHcrcHi      = 4'd11;
  localparam logic [IdxW-1:0] PosPcrcLo      = 4'd12;
  localparam logic [IdxW-1:0] PosPcrcHi      = 4'd13;
  localparam logic [IdxW-1:0] PosData        = 4'd0;
  localparam logic [IdxW-1:0] PosDataCrcLo   = 4'd1;
  localparam logic [IdxW-1:0] PosDataCrcHi   = 4'd2;

  job_t            job_q, job_d;
  logic            job_valid_q, job_valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     hcrc_q, hcrc_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic            out_ready;
  logic            emit;
  logic [IdxW-1:0] last_idx;
  logic            is_last;
  logic [7:0]      cur_byte;
  logic            cur_end;
  logic            in_hcrc_span;

  always_comb begin
    if (job_q.is_hdr) begin
      last_idx = job_q.with_crc ? PosPcrcHi : PosHcrcHi;
    end else begin
      last_idx = job_q.with_crc ? PosDataCrcHi : PosData;
    end
  end

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign emit        = job_valid_q && out_ready;
  assign is_last     = (idx_q == last_idx);
  assign job_ready_o = !job_valid_q || (emit && is_last);

  assign in_hcrc_span = job_q.is_hdr && (idx_q >= PosVersion) && (idx_q <= PosLenHi);

  always_comb begin
    cur_byte = job_q.data;
    cur_end  = 1'b0;
    if (job_q.is_hdr) begin
      case (idx_q)
        PosStartFirst:  cur_byte = cfg_i.start_first;
        PosStartSecond: cur_byte = cfg_i.start_second;
        PosVersion:     cur_byte = cfg_i.version;
        PosType:        cur_byte = job_q.frame_type;
        PosSeqLo:       cur_byte = job_q.sequence_req[7:0];
        PosSeqHi:       cur_byte = job_q.sequence_req[15:8];
        PosCommand:     cur_byte = job_q.command;
        PosStatus:      cur_byte = job_q.status_code;
        PosLenLo:       cur_byte = job_q.payload_length[7:0];
        PosLenHi:       cur_byte = job_q.payload_length[15:8];
        PosHcrcLo:      cur_byte = hcrc_q[7:0];
        PosHcrcHi:      cur_byte = hcrc_q[15:8];
        PosPcrcLo:      cur_byte = job_q.crc[7:0];
        default: begin
          cur_byte = job_q.crc[15:8];
          cur_end  = 1'b1;
        end
      endcase
    end else begin
      case (idx_q)
        PosData:      cur_byte = job_q.data;
        PosDataCrcLo: cur_byte = job_q.crc[7:0];
        default: begin
          cur_byte = job_q.crc[15:8];
          cur_end  = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    job_d       = job_q;
    job_valid_d = job_valid_q;
    idx_d       = idx_q;
    hcrc_d      = hcrc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (emit) begin
      idx_d = idx_q + 4'd1;
      if (in_hcrc_span) begin
        hcrc_d = crc_fold(hcrc_q, cur_byte);
      end
      if (is_last) begin
        job_valid_d = 1'b0;
      end
    end

    if (job_load_i) begin
      job_d       = job_i;
      job_valid_d = 1'b1;
      idx_d       = '0;
      hcrc_d      = CrcInit;
    end

    if (out_ready) begin
      out_valid_d     = emit;
      out_d.out_byte  = cur_byte;
      out_d.frame_end = cur_end;
      out_d.run_last  = is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    idx_q  <= idx_d;
    hcrc_q <= hcrc_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/crc_framed_packet_encoder.sv @@
// ----------------------------------------------------------------------------
// crc_framed_packet_encoder: framed packet encoder with CRC-16/CCITT-FALSE
// Builds 12-byte headers with a header CRC, passes payload bytes through and
// closes each frame with the little-endian payload CRC.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------
//   in       | in        | in_valid_i / in_stall_o | in_data_i  (in_item_t)
//   out      | out       | out_valid_o / out_stall_i | out_data_o (out_item_t)
//   cfg      | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A header yields 12 result bytes, or 14 when its length is zero; a payload
// transaction yields one, or three for the last byte of a frame. The sequencer
// emits one byte per cycle and takes the next transaction in the cycle it
// emits the final byte of the current job, so payload streams at one per cycle.
// Reset clears the frame state, the config registers and both valid flags.
// An output stall holds the output register and, through it, the sequencer.
//
module crc_framed_packet_encoder
  import cfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,

  // input transactions
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,

  // result transactions
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,

  // configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t cfg;
  job_t job;
  logic job_valid;
  logic job_ready;
  logic in_accept;

  // Stall the input whenever the sequencer still has bytes left of a job
  // beyond this cycle; dropped payload bytes still need the slot free.
  assign in_stall_o = !job_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  cfe_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance frame state and build the job for this transaction.
  cfe_frame_ctrl u_frame_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .item_i      (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  // Hold the job and emit its bytes through the output register.
  cfe_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_load_i  (in_accept && job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ tb/cfe_frame_checker.sv @@
// ----------------------------------------------------------------------------
// cfe_frame_checker: frame byte predictor and comparator
// Watches the input, result and register channels of the encoder, works out
// the frame bytes each accepted transaction must produce and compares every
// accepted result with the oldest expected byte.
// ----------------------------------------------------------------------------
module cfe_frame_checker
  import cfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_o,
  input  in_item_t   in_data_i,
  input  logic       out_valid_o,
  input  logic       out_stall_i,
  input  out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output int         fail_count,
  output int         pending
);

  localparam logic [15:0] CrcSeed    = 16'hFFFF;
  localparam logic [15:0] CrcGen     = 16'h1021;

  out_item_t   frame_bytes_q[$];
  int          fails   = 0;
  int          waiting = 0;

  logic [7:0]  sof_first    = 8'h00;
  logic [7:0]  sof_second   = 8'h00;
  logic [7:0]  proto_ver    = 8'h00;
  logic [15:0] bytes_owed   = 16'h0000;
  logic [15:0] run_crc      = CrcSeed;
  logic        payload_open = 1'b0;

  assign fail_count = fails;
  assign pending    = waiting;

  // bit-serial CCITT update, MSB of the byte first
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CrcGen;
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
    fails++;
  endtask

  task automatic push_byte(logic [7:0] b, logic fe);
    out_item_t r;
    r.out_byte  = b;
    r.frame_end = fe;
    r.run_last  = 1'b0;
    frame_bytes_q.push_back(r);
  endtask

  task automatic push_crc(logic [15:0] crc);
    push_byte(crc[7:0], 1'b0);
    push_byte(crc[15:8], 1'b1);
  endtask

  task automatic predict_frame_bytes(in_item_t it);
    logic [7:0]  hb[12];
    logic [15:0] hc;
    int          first_new;
    out_item_t   tail;
    first_new = frame_bytes_q.size();
    if (it.operation == OP_HEADER) begin
      hb = '{sof_first, sof_second, proto_ver, it.frame_type,
             it.sequence_req[7:0], it.sequence_req[15:8], it.command,
             it.status_code, it.payload_length[7:0], it.payload_length[15:8],
             8'h00, 8'h00};
      hc = CrcSeed;
      for (int i = 2; i < 10; i++) begin
        hc = crc16_step(hc, hb[i]);
      end
      hb[10] = hc[7:0];
      hb[11] = hc[15:8];
      foreach (hb[i]) begin
        push_byte(hb[i], 1'b0);
      end
      // a new header drops whatever frame was open
      run_crc      = CrcSeed;
      bytes_owed   = it.payload_length;
      payload_open = (it.payload_length != 16'h0000);
      if (!payload_open) begin
        push_crc(run_crc);
      end
    end else if (payload_open && bytes_owed != 16'h0000) begin
      push_byte(it.payload_byte, 1'b0);
      run_crc    = crc16_step(run_crc, it.payload_byte);
      bytes_owed = bytes_owed - 16'd1;
      if (bytes_owed == 16'h0000) begin
        payload_open = 1'b0;
        push_crc(run_crc);
      end
    end
    // mark the final byte caused by this transaction
    if (frame_bytes_q.size() > first_new) begin
      tail          = frame_bytes_q[frame_bytes_q.size() - 1];
      tail.run_last = 1'b1;
      frame_bytes_q[frame_bytes_q.size() - 1] = tail;
    end
  endtask

  // results first, so a transaction accepted at this edge cannot match them
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      frame_bytes_q.delete();
      sof_first    = 8'h00;
      sof_second   = 8'h00;
      proto_ver    = 8'h00;
      bytes_owed   = 16'h0000;
      run_crc      = CrcSeed;
      payload_open = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (frame_bytes_q.size() == 0) begin
          report_mismatch("result with nothing pending, byte", 8'h00, out_data_o.out_byte);
        end else begin
          want = frame_bytes_q.pop_front();
          if (out_data_o.out_byte !== want.out_byte) begin
            report_mismatch("out_byte", want.out_byte, out_data_o.out_byte);
          end
          if (out_data_o.frame_end !== want.frame_end) begin
            report_mismatch("frame_end", {7'd0, want.frame_end},
                            {7'd0, out_data_o.frame_end});
          end
          if (out_data_o.run_last !== want.run_last) begin
            report_mismatch("run_last", {7'd0, want.run_last},
                            {7'd0, out_data_o.run_last});
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_START_FIRST: begin
            sof_first = cfg_data_i;
          end
          REG_START_SECOND: begin
            sof_second = cfg_data_i;
          end
          REG_VERSION: begin
            proto_ver = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        predict_frame_bytes(in_data_i);
      end
    end
    waiting = frame_bytes_q.size();
  end

endmodule

@@ tb/tb_crc_framed_packet_encoder.sv @@
// ----------------------------------------------------------------------------
// tb_crc_framed_packet_encoder: self-checking bench for the framed encoder
// Drives header and payload transactions under random sender gaps and
// receiver stalls, rewrites the marker and version registers between phases
// and leaves prediction and comparison to the frame checker.
// ----------------------------------------------------------------------------
module tb_crc_framed_packet_encoder;
  import cfe_pkg::*;

  localparam int         RandomItems    = 370;
  localparam int         ResetCycles    = 6;
  localparam int         SettleCycles   = 16;
  localparam int         LongHoldCycles = 200;
  localparam int         FramesPerPhase = 10;
  localparam logic [1:0] RegUnused      = 2'd3;  // no register behind this index

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_item_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = REG_START_FIRST;
  logic [7:0] cfg_data_i  = 8'h00;
  int         fail_count;
  int         pending;

  // stimulus bookkeeping: payload bytes still owed by the open frame, and
  // the number of transactions the block actually acts on
  int         owed       = 0;
  int         live_items = 0;
  bit         gaps_on    = 1'b1;
  int         hold_ask   = 0;
  int         hold_seen  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  crc_framed_packet_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  cfe_frame_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Build a header transaction; the unused payload byte still gets noise so
  // that every input bit toggles.
  function automatic in_item_t header_item(logic [7:0] ft, logic [15:0] seq,
                                           logic [7:0] cmd, logic [7:0] st,
                                           logic [15:0] len);
    in_item_t it;
    it.operation      = OP_HEADER;
    it.frame_type     = ft;
    it.sequence_req   = seq;
    it.command        = cmd;
    it.status_code    = st;
    it.payload_length = len;
    it.payload_byte   = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Build a payload transaction with random junk in the header fields.
  function automatic in_item_t payload_item(logic [7:0] b);
    in_item_t it;
    it              = header_item(8'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 65535)),
                                  8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 65535)));
    it.operation    = OP_PAYLOAD;
    it.payload_byte = b;
    return it;
  endfunction

  function automatic in_item_t random_header(logic [15:0] len);
    return header_item(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len);
  endfunction

  // Mostly back-to-back, some short pauses, the odd long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Offer one transaction and hold it until accepted. Valid stays high when
  // no gap follows, so the next call simply replaces the payload.
  task automatic send_item(in_item_t it);
    int gap;
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (it.operation == OP_HEADER) begin
      owed = int'(it.payload_length);
      live_items++;
    end else if (owed > 0) begin
      owed--;
      live_items++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every expected byte has come out, then let
  // the block settle in case an ignored transaction is still in flight.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Leaves the register channel valid; the caller drops it after its last write.
  task automatic set_markers(logic [7:0] first, logic [7:0] second, logic [7:0] ver);
    drain();
    write_reg(REG_START_FIRST, first);
    write_reg(REG_START_SECOND, second);
    write_reg(REG_VERSION, ver);
  endtask

  // One random frame-level sequence: mostly complete frames with small
  // payloads, the rest truncated frames, stray bytes and empty frames.
  task automatic send_frame();
    int kind;
    int len;
    int cut;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      send_item(random_header(16'(len)));
      repeat (len) send_item(payload_item(8'($urandom_range(0, 255))));
    end else if (kind < 82) begin
      // leave the frame open; the next header abandons it
      len = $urandom_range(0, 1) ? $urandom_range(2, 65535) : $urandom_range(2, 30);
      cut = $urandom_range(0, (len > 4) ? 3 : 1);
      send_item(random_header(16'(len)));
      repeat (cut) send_item(payload_item(8'($urandom_range(0, 255))));
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 3)) send_item(payload_item(8'($urandom_range(0, 255))));
    end else begin
      send_item(random_header(16'h0000));
    end
  endtask

  // Receiver: alternate free runs and stalls; honour a long hold-off when
  // the stimulus asks for one.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat (($urandom_range(0, 99) < 30) ? $urandom_range(20, 60)
                                             : $urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                            : $urandom_range(1, 3)) @(posedge clk_i);
      end
    end
  end

  // Main stimulus and verdict.
  initial begin
    int phase;
    int frames;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the registers at their reset value.
    // A payload byte with nothing owed must vanish.
    send_item(payload_item(8'h5A));
    // All-zero header with an empty payload: CRC bytes FF FF follow at once.
    send_item(header_item(8'h00, 16'h0000, 8'h00, 8'h00, 16'h0000));
    // All-ones header, two bytes, then abandon it with a fresh header.
    send_item(header_item(8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF));
    send_item(payload_item(8'hFF));
    send_item(payload_item(8'h00));
    send_item(header_item(8'h3C, 16'h1234, 8'hA5, 8'h5A, 16'h0001));
    send_item(payload_item(8'hFF));
    // Frame closed: stray byte ignored.
    send_item(payload_item(8'h00));
    send_item(header_item(8'h80, 16'h8001, 8'h01, 8'h80, 16'h0002));
    send_item(payload_item(8'h00));
    send_item(payload_item(8'h80));
    send_item(header_item(8'h01, 16'h00FF, 8'h7F, 8'hFE, 16'h0100));
    send_item(payload_item(8'h01));

    // Registers at the upper extreme; a write to the spare index is dropped.
    set_markers(8'hFF, 8'hFF, 8'hFF);
    write_reg(RegUnused, 8'h42);
    cfg_valid_i <= 1'b0;
    send_item(header_item(8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 16'h0000));
    send_item(header_item(8'h00, 16'h0000, 8'h00, 8'h00, 16'h0003));
    send_item(payload_item(8'hAA));
    send_item(payload_item(8'h55));
    send_item(payload_item(8'hFF));

    // Random phases, each with its own register setting.
    live_items = 0;
    phase      = 0;
    while (live_items < RandomItems) begin
      if (phase == 0) begin
        set_markers(8'h00, 8'h00, 8'h00);
      end else begin
        set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      end
      if (phase == 3) begin
        write_reg(RegUnused, 8'($urandom_range(0, 255)));
      end
      cfg_valid_i <= 1'b0;
      gaps_on = (phase % 3 != 1);
      // Hold the receiver off and keep feeding so the block backs up.
      if (phase == 2) begin
        gaps_on = 1'b0;
        hold_ask++;
      end
      frames = 0;
      while (frames < FramesPerPhase && live_items < RandomItems) begin
        send_frame();
        frames++;
      end
      phase++;
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #10000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ crc_framed_packet_encoder.f @@
design/cfe_pkg.sv
design/cfe_cfg_regs.sv
design/cfe_frame_ctrl.sv
design/cfe_serializer.sv
design/crc_framed_packet_encoder.sv
tb/cfe_frame_checker.sv
tb/tb_crc_framed_packet_encoder.sv
